>>> src/dpb_pkg.sv
package dpb_pkg;

	// Default pixel index widths.
	localparam int COLUMN_BITS_DEF = 11;
	localparam int ROW_BITS_DEF    = 11;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INV_FOCAL_X      = 3'd0,
		REG_INV_FOCAL_Y      = 3'd1,
		REG_CENTRE_X         = 3'd2,
		REG_CENTRE_Y         = 3'd3,
		REG_INV_DEPTH_SCALE  = 3'd4,
		REG_POSE_ROTATION    = 3'd5,
		REG_POSE_TRANSLATION = 3'd6
	} cfg_reg_t;

	// Register values after reset: 1/fx = 1/fy = 2^-9, centre (320, 240),
	// one raw unit = 1 mm, identity rotation, no translation.
	localparam logic [31:0] INV_FOCAL_X_RST      = 32'd8388608;
	localparam logic [31:0] INV_FOCAL_Y_RST      = 32'd8388608;
	localparam logic [15:0] CENTRE_X_RST         = 16'd5120;
	localparam logic [15:0] CENTRE_Y_RST         = 16'd3840;
	localparam logic [31:0] INV_DEPTH_SCALE_RST  = 32'd4294967;
	localparam logic [63:0] POSE_ROTATION_RST    = 64'd16384;
	localparam logic [59:0] POSE_TRANSLATION_RST = 60'd0;

	// Camera frame coordinates are clipped to Q19.16 (36 bits signed).
	localparam int CAM_W  = 36;
	// Rotation matrix entries: Q.28 sums need 34 bits, Q.16 entries 22 bits.
	localparam int ROT_W  = 34;
	localparam int R_W    = ROT_W - 12;
	localparam int PROD_W = R_W + CAM_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int WLD_W  = ACC_W - 16;

	typedef logic signed [CAM_W-1:0] cam_coord_t;
	typedef logic signed [R_W-1:0]   rot_elem_t;
	typedef logic signed [ROT_W-1:0] rot_sum_t;

	// Per-pixel sideband that rides along the pipeline.
	typedef struct packed {
		logic       dnz;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       sat;
	} side_t;

	// Q.28 to Q.16, rounding halves away from zero.
	function automatic rot_elem_t rot_round(input rot_sum_t r);
		logic [ROT_W-1:0] sum;
		sum = r + ROT_W'(11'h7FF) + ROT_W'(!r[ROT_W-1]);
		return sum[ROT_W-1:12];
	endfunction

endpackage

>>> src/depth_pixel_backprojection_top.sv
// An accepted pixel word passes the stage registers s1 to s9 and leaves as its point word.
// Throughput: one pixel word per cycle; a stall at the output freezes every stage.
// Reset (arst_n low, asynchronous): all stage valid bits clear, and the camera
// intrinsics and pose registers return to their defaults (1/f = 2^-9, centre at
// (320, 240), 1 mm depth units, identity pose).
module depth_pixel_backprojection_top #(
	parameter int COLUMN_BITS = dpb_pkg::COLUMN_BITS_DEF,
	parameter int ROW_BITS    = dpb_pkg::ROW_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [dpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Pixel channel.
	input  logic                             pixel_valid,
	output logic                             pixel_ready,
	input  logic [COLUMN_BITS-1:0]           column,
	input  logic [ROW_BITS-1:0]              row,
	input  logic [15:0]                      raw_depth,
	input  logic [7:0]                       blue,
	input  logic [7:0]                       green,
	input  logic [7:0]                       red,
	// Point channel.
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             point_valid,
	output logic signed [31:0]               world_x,
	output logic signed [31:0]               world_y,
	output logic signed [31:0]               world_z,
	output logic [7:0]                       point_red,
	output logic [7:0]                       point_green,
	output logic [7:0]                       point_blue,
	output logic                             saturated
);
	import dpb_pkg::*;

	// Pipeline overview. Every stage holds one word and all stages move together:
	//   s1  pixel offsets from the principal point, raw depth times 1/scale
	//   s2  depth rounded to Q16.16, offsets times 1/f
	//   s3  rays rounded to Q.16
	//   s4  rays times depth
	//   s5  camera point rounded and clipped to Q19.16
	//   s6  nine rotation products
	//   s7  row sums of the products
	//   s8  rounding bias and translation added
	//   s9  world point saturated to Q15.16; this is the output register
	// The rotation matrix is derived from the quaternion register by a separate
	// three-register chain that runs every cycle. Configuration must change only
	// while the pipeline is empty (the block does not enforce this); a pixel passes s1
	// to s5 before the rotation products, so the matrix has settled when it is used.

	// Offset widths: u*16 minus a 16-bit centre, plus a sign bit.
	localparam int DU_W  = ((COLUMN_BITS + 4 > 16) ? COLUMN_BITS + 4 : 16) + 1;
	localparam int DV_W  = ((ROW_BITS + 4 > 16) ? ROW_BITS + 4 : 16) + 1;
	// Offset times an unsigned Q0.32 reciprocal, then the ray after a 20-bit shift.
	localparam int RUP_W = DU_W + 33;
	localparam int RVP_W = DV_W + 33;
	localparam int RU_W  = RUP_W - 20;
	localparam int RV_W  = RVP_W - 20;
	// Ray times the unsigned Q16.16 depth, then the camera coordinate before clipping.
	localparam int CPX_W = RU_W + 33;
	localparam int CPY_W = RV_W + 33;
	localparam int CRX_W = CPX_W - 16;
	localparam int CRY_W = CPY_W - 16;

	localparam cam_coord_t CAM_MAX = {1'b0, {(CAM_W-1){1'b1}}};
	localparam cam_coord_t CAM_MIN = {1'b1, {(CAM_W-1){1'b0}}};
	localparam rot_sum_t   ONE_Q28 = ROT_W'(29'h1000_0000);

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [31:0] inv_focal_x_q;
	logic [31:0] inv_focal_y_q;
	logic [15:0] centre_x_q;
	logic [15:0] centre_y_q;
	logic [31:0] inv_depth_scale_q;
	logic [63:0] pose_rotation_q;
	logic [59:0] pose_translation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q      <= INV_FOCAL_X_RST;
			inv_focal_y_q      <= INV_FOCAL_Y_RST;
			centre_x_q         <= CENTRE_X_RST;
			centre_y_q         <= CENTRE_Y_RST;
			inv_depth_scale_q  <= INV_DEPTH_SCALE_RST;
			pose_rotation_q    <= POSE_ROTATION_RST;
			pose_translation_q <= POSE_TRANSLATION_RST;
		end else if (cfg_we) begin
			// Writes to an index past the register list fall into the default arm.
			unique case (cfg_reg_t'(cfg_index))
				REG_INV_FOCAL_X:      inv_focal_x_q      <= cfg_data[31:0];
				REG_INV_FOCAL_Y:      inv_focal_y_q      <= cfg_data[31:0];
				REG_CENTRE_X:         centre_x_q         <= cfg_data[15:0];
				REG_CENTRE_Y:         centre_y_q         <= cfg_data[15:0];
				REG_INV_DEPTH_SCALE:  inv_depth_scale_q  <= cfg_data[31:0];
				REG_POSE_ROTATION:    pose_rotation_q    <= cfg_data;
				REG_POSE_TRANSLATION: pose_translation_q <= cfg_data[59:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Rotation matrix from the quaternion (w lowest), free running
	// ------------------------------------------------------------------------
	logic signed [15:0] qw, qx, qy, qz;
	logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	rot_sum_t           r28_q [3][3];
	rot_elem_t          r16_q [3][3];

	assign qw = pose_rotation_q[15:0];
	assign qx = pose_rotation_q[31:16];
	assign qy = pose_rotation_q[47:32];
	assign qz = pose_rotation_q[63:48];

	always_ff @(posedge clk) begin
		xx_q <= qx * qx;
		yy_q <= qy * qy;
		zz_q <= qz * qz;
		xy_q <= qx * qy;
		xz_q <= qx * qz;
		yz_q <= qy * qz;
		wx_q <= qw * qx;
		wy_q <= qw * qy;
		wz_q <= qw * qz;
	end

	// The unit-quaternion formula, applied as is to any quaternion: the norm
	// is taken as exactly one.
	always_ff @(posedge clk) begin
		r28_q[0][0] <= ONE_Q28 - ((ROT_W'(yy_q) + ROT_W'(zz_q)) <<< 1);
		r28_q[0][1] <= (ROT_W'(xy_q) - ROT_W'(wz_q)) <<< 1;
		r28_q[0][2] <= (ROT_W'(xz_q) + ROT_W'(wy_q)) <<< 1;
		r28_q[1][0] <= (ROT_W'(xy_q) + ROT_W'(wz_q)) <<< 1;
		r28_q[1][1] <= ONE_Q28 - ((ROT_W'(xx_q) + ROT_W'(zz_q)) <<< 1);
		r28_q[1][2] <= (ROT_W'(yz_q) - ROT_W'(wx_q)) <<< 1;
		r28_q[2][0] <= (ROT_W'(xz_q) - ROT_W'(wy_q)) <<< 1;
		r28_q[2][1] <= (ROT_W'(yz_q) + ROT_W'(wx_q)) <<< 1;
		r28_q[2][2] <= ONE_Q28 - ((ROT_W'(xx_q) + ROT_W'(yy_q)) <<< 1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r16_q[i][j] <= rot_round(r28_q[i][j]);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Flow control: one enable for all stages. The pipeline moves whenever the
	// output register is empty or its word is being taken.
	// ------------------------------------------------------------------------
	logic advance;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	assign advance     = !valid_s9 || result_ready;
	assign pixel_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pixel_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------------
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;

	logic signed [DU_W-1:0]  du_s1;
	logic signed [DV_W-1:0]  dv_s1;
	logic [47:0]             dprod_s1;

	logic [31:0]             depth_s2;
	logic signed [RUP_W-1:0] ruprod_s2;
	logic signed [RVP_W-1:0] rvprod_s2;

	logic [31:0]             depth_s3;
	logic signed [RU_W-1:0]  ru_s3;
	logic signed [RV_W-1:0]  rv_s3;

	logic [31:0]             depth_s4;
	logic signed [CPX_W-1:0] cpx_s4;
	logic signed [CPY_W-1:0] cpy_s4;

	cam_coord_t              p_s5 [3];

	logic signed [PROD_W-1:0] prod_s6 [3][3];
	logic signed [ACC_W-1:0]  acc_s7 [3];
	logic signed [ACC_W-1:0]  sum_s8 [3];

	logic                    point_valid_s9;
	logic signed [31:0]      world_s9 [3];
	logic [7:0]              red_s9, green_s9, blue_s9;
	logic                    sat_s9;

	// s1: offsets of the pixel from the principal point (Q.4) and the raw depth
	// times the depth reciprocal.
	side_t side_in;

	always_comb begin
		side_in.dnz   = (raw_depth != 16'd0);
		side_in.red   = red;
		side_in.green = green;
		side_in.blue  = blue;
		side_in.sat   = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s1  <= side_in;
			du_s1    <= $signed(DU_W'({column, 4'b0000})) - $signed(DU_W'(centre_x_q));
			dv_s1    <= $signed(DV_W'({row, 4'b0000})) - $signed(DV_W'(centre_y_q));
			dprod_s1 <= 48'(raw_depth) * 48'(inv_depth_scale_q);
		end
	end

	// s2: depth rounded to Q16.16; it always fits 32 bits. Offsets times 1/f.
	logic [47:0] depth_round;

	assign depth_round = dprod_s1 + 48'h8000;

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s2   <= side_s1;
			depth_s2  <= depth_round[47:16];
			ruprod_s2 <= du_s1 * $signed({1'b0, inv_focal_x_q});
			rvprod_s2 <= dv_s1 * $signed({1'b0, inv_focal_y_q});
		end
	end

	// s3: rays rounded to Q.16. Adding 2^(n-1) - 1 plus one for non-negative
	// values and then shifting rounds halves away from zero.
	logic [RUP_W-1:0] ru_round;
	logic [RVP_W-1:0] rv_round;

	assign ru_round = ruprod_s2 + RUP_W'(19'h7FFFF) + RUP_W'(!ruprod_s2[RUP_W-1]);
	assign rv_round = rvprod_s2 + RVP_W'(19'h7FFFF) + RVP_W'(!rvprod_s2[RVP_W-1]);

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s3  <= side_s2;
			depth_s3 <= depth_s2;
			ru_s3    <= ru_round[RUP_W-1:20];
			rv_s3    <= rv_round[RVP_W-1:20];
		end
	end

	// s4: rays times depth.
	always_ff @(posedge clk) begin
		if (advance) begin
			side_s4  <= side_s3;
			depth_s4 <= depth_s3;
			cpx_s4   <= ru_s3 * $signed({1'b0, depth_s3});
			cpy_s4   <= rv_s3 * $signed({1'b0, depth_s3});
		end
	end

	// s5: camera point rounded to Q.16 and clipped to 36 bits. Only a clip at the
	// positive end counts as saturation: a clip at the negative limit is not
	// flagged.
	logic [CPX_W-1:0] cx_round;
	logic [CPY_W-1:0] cy_round;
	logic [CRX_W-1:0] crx;
	logic [CRY_W-1:0] cry;
	logic             x_pos_ovf, x_neg_ovf, y_pos_ovf, y_neg_ovf;
	cam_coord_t       px_clip, py_clip;
	side_t            side_s5_next;

	assign cx_round = cpx_s4 + CPX_W'(15'h7FFF) + CPX_W'(!cpx_s4[CPX_W-1]);
	assign cy_round = cpy_s4 + CPY_W'(15'h7FFF) + CPY_W'(!cpy_s4[CPY_W-1]);
	assign crx      = cx_round[CPX_W-1:16];
	assign cry      = cy_round[CPY_W-1:16];

	always_comb begin
		x_pos_ovf = !crx[CRX_W-1] && (|crx[CRX_W-2:CAM_W-1]);
		x_neg_ovf = crx[CRX_W-1] && !(&crx[CRX_W-2:CAM_W-1]);
		y_pos_ovf = !cry[CRY_W-1] && (|cry[CRY_W-2:CAM_W-1]);
		y_neg_ovf = cry[CRY_W-1] && !(&cry[CRY_W-2:CAM_W-1]);

		priority if (x_pos_ovf) px_clip = CAM_MAX;
		else if (x_neg_ovf)     px_clip = CAM_MIN;
		else                    px_clip = crx[CAM_W-1:0];

		priority if (y_pos_ovf) py_clip = CAM_MAX;
		else if (y_neg_ovf)     py_clip = CAM_MIN;
		else                    py_clip = cry[CAM_W-1:0];

		side_s5_next     = side_s4;
		side_s5_next.sat = x_pos_ovf || y_pos_ovf;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s5 <= side_s5_next;
			p_s5[0] <= px_clip;
			p_s5[1] <= py_clip;
			p_s5[2] <= CAM_W'(depth_s4);
		end
	end

	// s6: the nine rotation products.
	always_ff @(posedge clk) begin
		if (advance) begin
			side_s6 <= side_s5;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s6[i][j] <= r16_q[i][j] * p_s5[j];
				end
			end
		end
	end

	// s7: row sums.
	always_ff @(posedge clk) begin
		if (advance) begin
			side_s7 <= side_s6;
			for (int i = 0; i < 3; i++) begin
				acc_s7[i] <= ACC_W'(prod_s6[i][0]) + ACC_W'(prod_s6[i][1])
					+ ACC_W'(prod_s6[i][2]);
			end
		end
	end

	// s8: the translation (Q7.12) is folded in below the rounding shift as
	// t * 2^20, which is a multiple of 2^16 and so does not disturb the rounding.
	logic signed [ACC_W-1:0] trans_ext [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trans_ext[i] = ACC_W'($signed(pose_translation_q[20*i +: 20])) <<< 20;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s8 <= side_s7;
			for (int i = 0; i < 3; i++) begin
				sum_s8[i] <= acc_s7[i] + trans_ext[i] + ACC_W'(15'h7FFF)
					+ ACC_W'(!acc_s7[i][ACC_W-1]);
			end
		end
	end

	// s9: shift to Q.16 and saturate to 32 bits. A pixel with no depth
	// measurement leaves an all-zero word.
	logic [WLD_W-1:0]   wide_w [3];
	logic signed [31:0] world_next [3];
	logic [2:0]         world_ovf;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_w[i] = sum_s8[i][ACC_W-1:16];
			world_ovf[i] = 1'b0;
			if (!wide_w[i][WLD_W-1] && (|wide_w[i][WLD_W-2:31])) begin
				world_next[i] = 32'sh7FFF_FFFF;
				world_ovf[i]  = 1'b1;
			end else if (wide_w[i][WLD_W-1] && !(&wide_w[i][WLD_W-2:31])) begin
				world_next[i] = 32'sh8000_0000;
				world_ovf[i]  = 1'b1;
			end else begin
				world_next[i] = wide_w[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			point_valid_s9 <= side_s8.dnz;
			if (side_s8.dnz) begin
				for (int i = 0; i < 3; i++) begin
					world_s9[i] <= world_next[i];
				end
				red_s9   <= side_s8.red;
				green_s9 <= side_s8.green;
				blue_s9  <= side_s8.blue;
				sat_s9   <= side_s8.sat || (|world_ovf);
			end else begin
				for (int i = 0; i < 3; i++) begin
					world_s9[i] <= 32'sd0;
				end
				red_s9   <= 8'd0;
				green_s9 <= 8'd0;
				blue_s9  <= 8'd0;
				sat_s9   <= 1'b0;
			end
		end
	end

	assign result_valid = valid_s9;
	assign point_valid  = point_valid_s9;
	assign world_x      = world_s9[0];
	assign world_y      = world_s9[1];
	assign world_z      = world_s9[2];
	assign point_red    = red_s9;
	assign point_green  = green_s9;
	assign point_blue   = blue_s9;
	assign saturated    = sat_s9;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_invalid_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !point_valid |-> world_x == 32'sd0 && world_y == 32'sd0
			&& world_z == 32'sd0 && point_red == 8'd0 && point_green == 8'd0
			&& point_blue == 8'd0 && !saturated)
		else $error("invalid point word carries nonzero fields");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("word lost between first and second stage");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5,
			valid_s6, valid_s7, valid_s8, valid_s9}))
		else $error("pipeline moved during a stall");

	a_output_refills: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s8 && result_ready |=> result_valid)
		else $error("word in last inner stage did not reach the output");

endmodule
